// File: sv/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types, constants and header table for the flagged LZ decompressor.
// ----------------------------------------------------------------------------
package lzd_pkg;

   localparam int HISTORY_DEPTH = 4096;
   localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
   localparam int COUNT_W       = HIST_AW + 1;

   localparam int HEADER_LEN     = 40;
   localparam int HEADER_CHECKED = 36;
   localparam int MAGIC_END      = 4;
   localparam int ENC_ID_END     = 20;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_MAGIC  = 3'd1;
   localparam logic [2:0] ST_BAD_ENC_ID = 3'd2;
   localparam logic [2:0] ST_BAD_FMT_ID = 3'd3;
   localparam logic [2:0] ST_BAD_OFFSET = 3'd4;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_RAW,
      PH_MASK_LO,
      PH_MASK_HI,
      PH_TOKEN,
      PH_PAIR_HI
   } phase_type;

   typedef enum logic [1:0] {
      CMD_LIT,
      CMD_ERR,
      CMD_COPY
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_COPY
   } back_state_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [7:0]         data;
      logic [2:0]         status;
      logic [HIST_AW-1:0] off_m1;
      logic [3:0]         len_m3;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] header_byte(input logic [5:0] idx);
      logic [7:0] b;
      case (idx)
         6'd0:  b = 8'h56;  6'd1:  b = 8'h4B;  6'd2:  b = 8'h56;  6'd3:  b = 8'h03;
         6'd4:  b = 8'h46;  6'd5:  b = 8'h1A;  6'd6:  b = 8'h79;  6'd7:  b = 8'h95;
         6'd8:  b = 8'hBC;  6'd9:  b = 8'h95;  6'd10: b = 8'h6C;  6'd11: b = 8'h4F;
         6'd12: b = 8'hA7;  6'd13: b = 8'h0B;  6'd14: b = 8'h05;  6'd15: b = 8'hBC;
         6'd16: b = 8'hA1;  6'd17: b = 8'hB7;  6'd18: b = 8'hDF;  6'd19: b = 8'hD2;
         6'd20: b = 8'h7C;  6'd21: b = 8'h16;  6'd22: b = 8'h12;  6'd23: b = 8'h74;
         6'd24: b = 8'hE9;  6'd25: b = 8'h06;  6'd26: b = 8'h98;  6'd27: b = 8'h46;
         6'd28: b = 8'hAF;  6'd29: b = 8'hF2;  6'd30: b = 8'hE6;  6'd31: b = 8'h3E;
         6'd32: b = 8'hB5;  6'd33: b = 8'h90;  6'd34: b = 8'h37;  6'd35: b = 8'hE7;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [2:0] header_fail_status(input logic [5:0] idx);
      logic [2:0] st;
      if (idx < 6'(MAGIC_END)) begin
         st = ST_BAD_MAGIC;
      end else if (idx < 6'(ENC_ID_END)) begin
         st = ST_BAD_ENC_ID;
      end else begin
         st = ST_BAD_FMT_ID;
      end
      return st;
   endfunction

endpackage

// File: sv/lzd_front.sv
// ----------------------------------------------------------------------------
// lzd_front
// Stream parser: checks the header, splits the body into mask, literal and
// copy tokens, and issues one command per byte that gives results.
// ----------------------------------------------------------------------------
module lzd_front import lzd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_in_byte,
   input  logic             req_stream_last,
   input  queue_status_type q_status,
   output logic             cmd_push,
   output cmd_type          cmd
);

   phase_type          phase_ff, phase_in;
   logic [5:0]         hidx_ff, hidx_in;
   logic [15:0]        mask_ff, mask_in;
   logic [3:0]         tidx_ff, tidx_in;
   logic [7:0]         pair_low_ff, pair_low_in;
   logic               err_ff, err_in;
   logic [COUNT_W-1:0] wc_ff, wc_in;

   logic               accept;
   logic [15:0]        pair_word;
   logic [COUNT_W-1:0] offset;
   logic [4:0]         copy_len;
   logic               bad_offset;
   logic               hdr_bad;
   logic               mask_bit;
   logic [5:0]         hidx_next;
   logic [COUNT_W:0]   wc_sum;
   logic [4:0]         wc_add;

   assign req_stall  = q_status.full;
   assign accept     = req_valid & ~q_status.full;
   assign pair_word  = {req_in_byte, pair_low_ff};
   assign offset     = {1'b0, pair_word[15:4]} + COUNT_W'(1);
   assign copy_len   = {1'b0, pair_word[3:0]} + 5'd3;
   assign bad_offset = offset > wc_ff;
   assign hdr_bad    = (hidx_ff < 6'(HEADER_CHECKED)) && (req_in_byte != header_byte(hidx_ff));
   assign mask_bit   = mask_ff[tidx_ff];
   assign hidx_next  = hidx_ff + 6'd1;
   assign wc_sum     = {1'b0, wc_ff} + (COUNT_W+1)'(wc_add);

   // next state
   always_comb begin
      phase_in    = phase_ff;
      hidx_in     = hidx_ff;
      mask_in     = mask_ff;
      tidx_in     = tidx_ff;
      pair_low_in = pair_low_ff;
      err_in      = err_ff;
      wc_add      = 5'd0;
      if (accept && !err_ff) begin
         case (phase_ff)
            PH_HEADER: begin
               if (hdr_bad) begin
                  err_in = 1'b1;
               end else begin
                  wc_add  = 5'd1;
                  hidx_in = hidx_next;
                  if (hidx_next == 6'(HEADER_LEN)) begin
                     phase_in = req_in_byte[7] ? PH_RAW : PH_MASK_LO;
                  end
               end
            end
            PH_RAW: begin
               wc_add = 5'd1;
            end
            PH_MASK_LO: begin
               mask_in  = {8'h00, req_in_byte};
               phase_in = PH_MASK_HI;
            end
            PH_MASK_HI: begin
               mask_in  = {req_in_byte, mask_ff[7:0]};
               tidx_in  = 4'd0;
               phase_in = PH_TOKEN;
            end
            PH_TOKEN: begin
               if (mask_bit) begin
                  pair_low_in = req_in_byte;
                  phase_in    = PH_PAIR_HI;
               end else begin
                  wc_add   = 5'd1;
                  tidx_in  = tidx_ff + 4'd1;
                  phase_in = (tidx_ff == 4'd15) ? PH_MASK_LO : PH_TOKEN;
               end
            end
            PH_PAIR_HI: begin
               if (bad_offset) begin
                  err_in = 1'b1;
               end else begin
                  wc_add   = copy_len;
                  tidx_in  = tidx_ff + 4'd1;
                  phase_in = (tidx_ff == 4'd15) ? PH_MASK_LO : PH_TOKEN;
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end
      // count of valid history bytes, saturating at the window size
      if (wc_sum > (COUNT_W+1)'(HISTORY_DEPTH)) begin
         wc_in = COUNT_W'(HISTORY_DEPTH);
      end else begin
         wc_in = wc_sum[COUNT_W-1:0];
      end
      if (accept && req_stream_last) begin
         phase_in    = PH_HEADER;
         hidx_in     = 6'd0;
         mask_in     = 16'd0;
         tidx_in     = 4'd0;
         pair_low_in = 8'd0;
         err_in      = 1'b0;
         wc_in       = '0;
      end
   end

   // command outputs
   always_comb begin
      cmd_push    = 1'b0;
      cmd.kind    = CMD_LIT;
      cmd.data    = req_in_byte;
      cmd.status  = ST_OK;
      cmd.off_m1  = pair_word[15:4];
      cmd.len_m3  = pair_word[3:0];
      if (accept && !err_ff) begin
         case (phase_ff)
            PH_HEADER: begin
               cmd_push = 1'b1;
               if (hdr_bad) begin
                  cmd.kind   = CMD_ERR;
                  cmd.data   = 8'h00;
                  cmd.status = header_fail_status(hidx_ff);
               end
            end
            PH_RAW: begin
               cmd_push = 1'b1;
            end
            PH_TOKEN: begin
               cmd_push = ~mask_bit;
            end
            PH_PAIR_HI: begin
               cmd_push = 1'b1;
               if (bad_offset) begin
                  cmd.kind   = CMD_ERR;
                  cmd.data   = 8'h00;
                  cmd.status = ST_BAD_OFFSET;
               end else begin
                  cmd.kind = CMD_COPY;
               end
            end
            default: begin
               cmd_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hidx_ff     <= 6'd0;
         mask_ff     <= 16'd0;
         tidx_ff     <= 4'd0;
         pair_low_ff <= 8'd0;
         err_ff      <= 1'b0;
         wc_ff       <= '0;
      end else begin
         phase_ff    <= phase_in;
         hidx_ff     <= hidx_in;
         mask_ff     <= mask_in;
         tidx_ff     <= tidx_in;
         pair_low_ff <= pair_low_in;
         err_ff      <= err_in;
         wc_ff       <= wc_in;
      end
   end

endmodule

// File: sv/lzd_queue.sv
// ----------------------------------------------------------------------------
// lzd_queue
// Small command FIFO between the parser and the output engine.
// ----------------------------------------------------------------------------
module lzd_queue import lzd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head,
   output queue_status_type status
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/lzd_back.sv
// ----------------------------------------------------------------------------
// lzd_back
// Output engine: writes literals to the history window, expands copies one
// byte at a time from it, and holds the result word in an output register.
// ----------------------------------------------------------------------------
module lzd_back import lzd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          head,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic [2:0]       rsp_status,
   output logic             rsp_run_last
);

   back_state_type     state_ff, state_in;
   logic [HIST_AW-1:0] wp_ff, wp_in;
   logic [HIST_AW-1:0] off_m1_ff, off_m1_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               rd_ok_ff, rd_ok_in;
   logic [7:0]         rd_data_ff;
   logic [7:0]         hist [HISTORY_DEPTH];

   logic               rsp_valid_ff;
   logic [7:0]         rsp_out_byte_ff;
   logic [2:0]         rsp_status_ff;
   logic               rsp_run_last_ff;

   logic               can_load;
   logic               hist_we;
   logic [7:0]         hist_wdata;
   logic               load;
   logic [7:0]         load_byte;
   logic [2:0]         load_status;
   logic               load_last;
   logic [HIST_AW-1:0] rd_addr;

   assign can_load = ~rsp_valid_ff | ~rsp_stall;
   assign rd_addr  = wp_ff - off_m1_ff - HIST_AW'(1);

   // outputs
   always_comb begin
      pop         = 1'b0;
      hist_we     = 1'b0;
      hist_wdata  = head.data;
      load        = 1'b0;
      load_byte   = head.data;
      load_status = head.status;
      load_last   = 1'b1;
      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               case (head.kind)
                  CMD_LIT: begin
                     pop     = can_load;
                     hist_we = can_load;
                     load    = can_load;
                  end
                  CMD_ERR: begin
                     pop  = can_load;
                     load = can_load;
                  end
                  CMD_COPY: begin
                     pop = 1'b1;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         BK_COPY: begin
            // read data is only good when rd_ok_ff marks a history read registered after the last write
            if (rd_ok_ff && can_load) begin
               hist_we     = 1'b1;
               hist_wdata  = rd_data_ff;
               load        = 1'b1;
               load_byte   = rd_data_ff;
               load_status = ST_OK;
               load_last   = (cnt_ff == 5'd0);
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      off_m1_in = off_m1_ff;
      cnt_in    = cnt_ff;
      rd_ok_in  = 1'b0;
      wp_in     = hist_we ? wp_ff + HIST_AW'(1) : wp_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop && head.kind == CMD_COPY) begin
               state_in  = BK_COPY;
               off_m1_in = head.off_m1;
               cnt_in    = {1'b0, head.len_m3} + 5'd2;
            end
         end
         BK_COPY: begin
            if (hist_we) begin
               cnt_in = cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  state_in = BK_IDLE;
               end
            end else begin
               rd_ok_in = 1'b1;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist[wp_ff] <= hist_wdata;
      end
      rd_data_ff <= hist[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         wp_ff        <= '0;
         off_m1_ff    <= '0;
         cnt_ff       <= 5'd0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wp_ff     <= wp_in;
         off_m1_ff <= off_m1_in;
         cnt_ff    <= cnt_in;
         rd_ok_ff  <= rd_ok_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_out_byte_ff <= load_byte;
         rsp_status_ff   <= load_status;
         rsp_run_last_ff <= load_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_run_last = rsp_run_last_ff;

endmodule

// File: sv/flagged_lz_stream_decompressor_top.sv
// ----------------------------------------------------------------------------
// flagged_lz_stream_decompressor_top
// Flagged LZ stream decompressor with a 4096-byte history window.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one compressed byte per word, req_stream_last marks the
//   final byte of a stream. rsp_* returns decompressed bytes with a status
//   code; rsp_run_last flags the last word caused by one input byte.
//   A parser accepts bytes and queues commands (literal, error, copy) in a
//   4-entry queue; an output engine drains it into the history window and
//   a one-word output register.
//   A literal or error word passes through the command queue and then the
//   output register. A copy is popped, then gives its bytes one at a time
//   (history read, then write), so a copy of length L holds the engine
//   until all L bytes are out. Mask bytes and the first byte of a copy
//   produce nothing.
//   req_stall rises only while the command queue is full.
//   When rsp_stall is high the output word holds; the engine and then the
//   queue back up behind it.
//   Reset (synchronous) returns to header parsing and empties the queue;
//   history content is undefined until written. A byte with
//   req_stream_last also returns the parser to header parsing.
// ----------------------------------------------------------------------------
module flagged_lz_stream_decompressor_top import lzd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_stream_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_status,
   output logic       rsp_run_last
);

   queue_status_type q_status;
   cmd_type          push_cmd;
   cmd_type          head;
   logic             cmd_push;
   logic             cmd_pop;

   lzd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_stream_last (req_stream_last),
      .q_status        (q_status),
      .cmd_push        (cmd_push),
      .cmd             (push_cmd)
   );

   lzd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .pop      (cmd_pop),
      .head     (head),
      .status   (q_status)
   );

   lzd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_status     (q_status),
      .pop          (cmd_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_run_last (rsp_run_last)
   );

`ifndef NO_ASSERTIONS
   // error words carry a zero byte and close their input byte's run
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_run_last && rsp_out_byte == 8'h00))
      else $error("error word with nonzero byte or without run_last");

   // the parser never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(cmd_push && q_status.full))
      else $error("command pushed into full queue");

   // the engine never pops an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(cmd_pop && q_status.empty))
      else $error("command popped from empty queue");

   // an input byte is taken only when the queue has room
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> req_stall)
      else $error("input not stalled with full queue");
`endif

endmodule
